@@ design/ycbcr422_to_rgb_converter_assert.svh @@
// Assertion helpers shared by the converter RTL.
// All checks are clocked on clock and held off while reset is high.
`ifndef YCBCR422_TO_RGB_CONVERTER_ASSERT_SVH
`define YCBCR422_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication
`define YC2RGB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define YC2RGB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/yc2rgb_pkg.sv @@
`timescale 1ns / 1ps
package yc2rgb_pkg;

   // Field widths
   localparam int PIX_W  = 8;
   localparam int TERM_W = 10;   // lookup terms lie within -231..228
   localparam int SUM_W  = 11;   // luma plus term lies within -231..483

   // Colour matrix coefficients in units of 1/10000
   localparam longint COEF_CRR      = 3646610;
   localparam longint COEF_CGB      = -898779;
   localparam longint COEF_CGR      = -1858154;
   localparam longint COEF_CBB      = 4605724;
   localparam longint COEF_SCALE    = 10000;
   localparam longint CHROMA_OFFSET = 128;
   localparam int     LUT_DEPTH     = 256;

   // Register map
   localparam int        CSR_ADDR_W           = 3;
   localparam int        CSR_DATA_W           = 32;
   localparam logic      CSR_IDX_CHROMA_ORDER = 1'b0;

   // Chroma ordering codes
   localparam logic CHROMA_CB_FIRST = 1'b0;
   localparam logic CHROMA_CR_FIRST = 1'b1;

   typedef logic signed [TERM_W-1:0] lut_type [LUT_DEPTH];

   // One packed 4:2:2 pixel pair
   typedef struct packed {
      logic [PIX_W-1:0] luma_first;
      logic [PIX_W-1:0] chroma_a;
      logic [PIX_W-1:0] luma_second;
      logic [PIX_W-1:0] chroma_b;
      logic             last_pair;
   } pair_type;

   // Two RGB pixels
   typedef struct packed {
      logic [PIX_W-1:0] red_first;
      logic [PIX_W-1:0] green_first;
      logic [PIX_W-1:0] blue_first;
      logic [PIX_W-1:0] red_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] blue_second;
      logic             last_out;
   } rgb_pair_type;

   // Table of floor(trunc(coef * (c - 128) / 10000) / 256), built at elaboration
   function automatic lut_type build_lut(input longint coef);
      lut_type tbl;
      longint  q;
      for (int c = 0; c < LUT_DEPTH; c++) begin
         q = (coef * (longint'(c) - CHROMA_OFFSET)) / COEF_SCALE;
         tbl[c] = TERM_W'(q >>> 8);
      end
      return tbl;
   endfunction

   localparam lut_type LUT_CRR = build_lut(COEF_CRR);
   localparam lut_type LUT_CGB = build_lut(COEF_CGB);
   localparam lut_type LUT_CGR = build_lut(COEF_CGR);
   localparam lut_type LUT_CBB = build_lut(COEF_CBB);

   // Saturate a signed sum to 0..255
   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] v);
      logic [PIX_W-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (|v[SUM_W-2:PIX_W]) begin
         r = '1;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/yc2rgb_in_stage.sv @@
`timescale 1ns / 1ps
module yc2rgb_in_stage
   import yc2rgb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  pair_type req_pair,
   input  logic     down_ready,
   output logic     pair_valid,
   output pair_type pair
);

   logic     valid_ff, valid_in;
   pair_type pair_ff;
   logic     load_ok;

   // Stage may take a new transaction when empty or when it is draining
   assign load_ok   = !valid_ff || down_ready;
   assign req_stall = !load_ok;

   always_comb begin
      valid_in = valid_ff;
      if (load_ok) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load_ok && req_valid) begin
         pair_ff <= req_pair;
      end
   end

   assign pair_valid = valid_ff;
   assign pair       = pair_ff;

endmodule

@@ design/yc2rgb_calc.sv @@
`timescale 1ns / 1ps
module yc2rgb_calc
   import yc2rgb_pkg::*;
(
   input  logic         chroma_order,
   input  pair_type     pair,
   output rgb_pair_type rgb
);

   logic [PIX_W-1:0]        cb, cr;
   logic signed [TERM_W-1:0] term_r, term_gb, term_gr, term_b;
   logic signed [SUM_W-1:0]  tr, tg, tb, y0, y1;

   // Pick Cb and Cr from the two chroma bytes
   always_comb begin
      unique case (chroma_order)
         CHROMA_CB_FIRST: begin
            cb = pair.chroma_a;
            cr = pair.chroma_b;
         end
         CHROMA_CR_FIRST: begin
            cr = pair.chroma_a;
            cb = pair.chroma_b;
         end
         default: begin
            cb = pair.chroma_a;
            cr = pair.chroma_b;
         end
      endcase
   end

   // Constant table lookups
   assign term_r  = LUT_CRR[cr];
   assign term_gb = LUT_CGB[cb];
   assign term_gr = LUT_CGR[cr];
   assign term_b  = LUT_CBB[cb];

   assign tr = SUM_W'(term_r);
   assign tg = SUM_W'(term_gb) + SUM_W'(term_gr);
   assign tb = SUM_W'(term_b);

   assign y0 = $signed({{(SUM_W-PIX_W){1'b0}}, pair.luma_first});
   assign y1 = $signed({{(SUM_W-PIX_W){1'b0}}, pair.luma_second});

   // Add to each luma and saturate
   assign rgb.red_first    = clamp_pix(y0 + tr);
   assign rgb.green_first  = clamp_pix(y0 + tg);
   assign rgb.blue_first   = clamp_pix(y0 + tb);
   assign rgb.red_second   = clamp_pix(y1 + tr);
   assign rgb.green_second = clamp_pix(y1 + tg);
   assign rgb.blue_second  = clamp_pix(y1 + tb);
   assign rgb.last_out     = pair.last_pair;

endmodule

@@ design/yc2rgb_out_stage.sv @@
`timescale 1ns / 1ps
module yc2rgb_out_stage
   import yc2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rgb_pair_type in_rgb,
   output logic         up_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rgb_pair_type rsp_rgb
);

   logic         valid_ff, valid_in;
   rgb_pair_type rgb_ff;

   // Result register frees when empty or when its transaction is taken
   assign up_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         rgb_ff <= in_rgb;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_rgb   = rgb_ff;

endmodule

@@ design/ycbcr422_to_rgb_converter.sv @@
`timescale 1ns / 1ps
// A pair passes through the input register, then the result register, before its result
// is valid. Throughput: one pixel pair per cycle while rsp_stall is low; table lookups,
// adds and clamps fit between the two registers, so the next transaction enters while the
// previous one is waiting to be taken.
// Reset (synchronous, active high) empties both stages and sets chroma_order to Cb first.
module ycbcr422_to_rgb_converter
   import yc2rgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_luma_first,
   input  logic [PIX_W-1:0]      req_chroma_a,
   input  logic [PIX_W-1:0]      req_luma_second,
   input  logic [PIX_W-1:0]      req_chroma_b,
   input  logic                  req_last_pair,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_red_first,
   output logic [PIX_W-1:0]      rsp_green_first,
   output logic [PIX_W-1:0]      rsp_blue_first,
   output logic [PIX_W-1:0]      rsp_red_second,
   output logic [PIX_W-1:0]      rsp_green_second,
   output logic [PIX_W-1:0]      rsp_blue_second,
   output logic                  rsp_last_out,
   // Register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

`include "ycbcr422_to_rgb_converter_assert.svh"

   logic         chroma_order_ff, chroma_order_in;
   logic         csr_wr, csr_hit;
   pair_type     req_pair, s1_pair;
   logic         s1_valid, out_ready;
   rgb_pair_type calc_rgb, rsp_rgb;

   // Register port: single-bit chroma order at index 0
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_CHROMA_ORDER);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      chroma_order_in = chroma_order_ff;
      if (csr_wr && csr_hit) begin
         chroma_order_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chroma_order_ff <= CHROMA_CB_FIRST;
      end else begin
         chroma_order_ff <= chroma_order_in;
      end
   end

   assign prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, chroma_order_ff} : '0;

   // Input register
   assign req_pair = '{luma_first:  req_luma_first,
                       chroma_a:    req_chroma_a,
                       luma_second: req_luma_second,
                       chroma_b:    req_chroma_b,
                       last_pair:   req_last_pair};

   yc2rgb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pair   (req_pair),
      .down_ready (out_ready),
      .pair_valid (s1_valid),
      .pair       (s1_pair)
   );

   // Lookups, sums and clamps
   yc2rgb_calc u_calc (
      .chroma_order (chroma_order_ff),
      .pair         (s1_pair),
      .rgb          (calc_rgb)
   );

   // Result register
   yc2rgb_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_rgb    (calc_rgb),
      .up_ready  (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rgb   (rsp_rgb)
   );

   assign rsp_red_first    = rsp_rgb.red_first;
   assign rsp_green_first  = rsp_rgb.green_first;
   assign rsp_blue_first   = rsp_rgb.blue_first;
   assign rsp_red_second   = rsp_rgb.red_second;
   assign rsp_green_second = rsp_rgb.green_second;
   assign rsp_blue_second  = rsp_rgb.blue_second;
   assign rsp_last_out     = rsp_rgb.last_out;

   // Checks
   `YC2RGB_ASSERT_NOW(a_full_pipe_stalls, s1_valid && rsp_valid && rsp_stall,
      req_stall, "input not stalled with both stages blocked")
   `YC2RGB_ASSERT_NEXT(a_accept_fills_s1, req_valid && !req_stall,
      s1_valid, "accepted transaction lost at input register")
   `YC2RGB_ASSERT_NEXT(a_s1_moves_out, s1_valid && out_ready,
      rsp_valid, "transaction lost between stages")
   `YC2RGB_ASSERT_NEXT(a_csr_write, csr_wr && csr_hit,
      chroma_order_ff == $past(pwdata[0]), "chroma order write not taken")

endmodule

@@ tb/ycbcr422_to_rgb_converter_test.sv @@
`timescale 1ns / 1ps
module ycbcr422_to_rgb_converter_test;
   import yc2rgb_pkg::*;

   // Colour matrix in units of 1/10000, kept apart from the design's copy
   localparam longint K_CR_TO_R = 3646610;
   localparam longint K_CB_TO_G = -898779;
   localparam longint K_CR_TO_G = -1858154;
   localparam longint K_CB_TO_B = 4605724;
   localparam longint K_SCALE   = 10000;
   localparam int     C_ZERO    = 128;

   // Register addresses: indices 0 to 3 all decode to the chroma order register, 4 is unmapped
   localparam logic [CSR_ADDR_W-1:0] ADDR_CHROMA_ORDER = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int N_PHASES        = 5;
   localparam int ITEMS_PER_PHASE = 320;

   // Per-phase chroma order and idling
   localparam logic PHASE_ORDER [N_PHASES] = '{CHROMA_CR_FIRST, CHROMA_CB_FIRST,
                                               CHROMA_CR_FIRST, CHROMA_CB_FIRST,
                                               CHROMA_CR_FIRST};
   localparam int   PHASE_SND   [N_PHASES] = '{0, 82, 0, 18, 18};
   localparam int   PHASE_RCV   [N_PHASES] = '{0, 0, 82, 18, 18};
   localparam bit   PHASE_HOLD  [N_PHASES] = '{1, 0, 0, 1, 0};
   localparam bit   PHASE_DRAIN [N_PHASES] = '{0, 0, 1, 0, 0};

   typedef struct {
      pair_type     pair;
      logic         order;
      bit           fixed;
      rgb_pair_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_luma_first = '0;
   logic [PIX_W-1:0]      req_chroma_a = '0;
   logic [PIX_W-1:0]      req_luma_second = '0;
   logic [PIX_W-1:0]      req_chroma_b = '0;
   logic                  req_last_pair = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_red_first;
   logic [PIX_W-1:0]      rsp_green_first;
   logic [PIX_W-1:0]      rsp_blue_first;
   logic [PIX_W-1:0]      rsp_red_second;
   logic [PIX_W-1:0]      rsp_green_second;
   logic [PIX_W-1:0]      rsp_blue_second;
   logic                  rsp_last_out;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Typed-in expectation travelling with the transaction on offer
   bit           row_is_fixed = 1'b0;
   rgb_pair_type row_want = '0;

   logic         chroma_order_model = CHROMA_CB_FIRST;
   rgb_pair_type pending_rgb [$];
   stim_row_type stim_table [$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           snd_pct = 0;
   int           rcv_pct = 0;
   int           hold_starts = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   ycbcr422_to_rgb_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_luma_first   (req_luma_first),
      .req_chroma_a     (req_chroma_a),
      .req_luma_second  (req_luma_second),
      .req_chroma_b     (req_chroma_b),
      .req_last_pair    (req_last_pair),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_first    (rsp_red_first),
      .rsp_green_first  (rsp_green_first),
      .rsp_blue_first   (rsp_blue_first),
      .rsp_red_second   (rsp_red_second),
      .rsp_green_second (rsp_green_second),
      .rsp_blue_second  (rsp_blue_second),
      .rsp_last_out     (rsp_last_out),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Lookup term: quotient by the scale truncates, quotient by 256 floors
   function automatic int chroma_term(input longint coef, input logic [PIX_W-1:0] c);
      longint scaled;
      scaled = (coef * (longint'(c) - C_ZERO)) / K_SCALE;
      if (scaled >= 0) begin
         return int'(scaled / 256);
      end
      return int'(-((-scaled + 255) / 256));
   endfunction

   function automatic logic [PIX_W-1:0] saturate(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 255) begin
         return '1;
      end
      return v[PIX_W-1:0];
   endfunction

   // Expected RGB pair for one 4:2:2 pair under the given chroma order
   function automatic rgb_pair_type convert_pair(input pair_type p, input logic order);
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
      int               tr;
      int               tg;
      int               tb;
      rgb_pair_type     r;
      if (order == CHROMA_CB_FIRST) begin
         cb = p.chroma_a;
         cr = p.chroma_b;
      end else begin
         cr = p.chroma_a;
         cb = p.chroma_b;
      end
      tr = chroma_term(K_CR_TO_R, cr);
      tg = chroma_term(K_CB_TO_G, cb) + chroma_term(K_CR_TO_G, cr);
      tb = chroma_term(K_CB_TO_B, cb);
      r.red_first    = saturate(int'(p.luma_first) + tr);
      r.green_first  = saturate(int'(p.luma_first) + tg);
      r.blue_first   = saturate(int'(p.luma_first) + tb);
      r.red_second   = saturate(int'(p.luma_second) + tr);
      r.green_second = saturate(int'(p.luma_second) + tg);
      r.blue_second  = saturate(int'(p.luma_second) + tb);
      r.last_out     = p.last_pair;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatches < 10) begin
         $display("%0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         flag_mismatch($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
      end
   endtask

   // Scoreboard: retire the oldest expectation, then record the new transaction
   always @(posedge clock) begin : track
      rgb_pair_type got;
      rgb_pair_type want;
      pair_type     taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_red_first, rsp_green_first, rsp_blue_first, rsp_red_second,
                    rsp_green_second, rsp_blue_second, rsp_last_out};
            if (pending_rgb.size() == 0) begin
               flag_mismatch("result transaction with nothing pending");
            end else begin
               want = pending_rgb.pop_front();
               check_field("red_first", got.red_first, want.red_first);
               check_field("green_first", got.green_first, want.green_first);
               check_field("blue_first", got.blue_first, want.blue_first);
               check_field("red_second", got.red_second, want.red_second);
               check_field("green_second", got.green_second, want.green_second);
               check_field("blue_second", got.blue_second, want.blue_second);
               check_field("last_out", got.last_out, want.last_out);
            end
         end
         if (req_valid && !req_stall) begin
            taken = '{req_luma_first, req_chroma_a, req_luma_second, req_chroma_b,
                      req_last_pair};
            if (row_is_fixed) begin
               pending_rgb.push_back(row_want);
            end else begin
               pending_rgb.push_back(convert_pair(taken, chroma_order_model));
            end
         end
      end
   end

   // Watchdog on cycles with no transaction accepted at the input or taken at the output
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[ycbcr422_to_rgb_converter] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_starts) begin
         hold_seen <= hold_starts;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_pct);
      end
   end

   // Setup, access, then idle before the next transfer
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_CHROMA_ORDER) begin
         chroma_order_model = data[0];
      end
      @(posedge clock);
   endtask

   // Read back chroma_order; data is taken in the middle of the access cycle
   task automatic csr_check();
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_CHROMA_ORDER;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      check_field("chroma_order readback", got,
                  {{(CSR_DATA_W-1){1'b0}}, chroma_order_model});
      @(posedge clock);
   endtask

   // Offer one transaction, after a random gap, and wait until it is taken
   task automatic send_pair(input pair_type p, input bit fixed, input rgb_pair_type want);
      if (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_pct);
      end
      req_valid       <= 1'b1;
      req_luma_first  <= p.luma_first;
      req_chroma_a    <= p.chroma_a;
      req_luma_second <= p.luma_second;
      req_chroma_b    <= p.chroma_b;
      req_last_pair   <= p.last_pair;
      row_is_fixed    <= fixed;
      row_want        <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering, wait for every pending result, then let the pipe run dry
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_row(input pair_type p, input logic order, input bit fixed,
                          input rgb_pair_type want);
      stim_row_type row;
      row.pair  = p;
      row.order = order;
      row.fixed = fixed;
      row.want  = want;
      stim_table.push_back(row);
   endtask

   // Bytes biased towards the extremes and the chroma zero point
   function automatic logic [PIX_W-1:0] pick_byte();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 8'd128;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p.luma_first  = pick_byte();
      p.chroma_a    = pick_byte();
      p.luma_second = pick_byte();
      p.chroma_b    = pick_byte();
      p.last_pair   = ($urandom_range(7) == 0);
      return p;
   endfunction

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] wd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: neutral chroma gives grey with exact values, the rest is predicted
      add_row(pair_type'{8'd0, 8'd128, 8'd0, 8'd128, 1'b0}, CHROMA_CB_FIRST, 1,
              rgb_pair_type'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
      add_row(pair_type'{8'd255, 8'd128, 8'd255, 8'd128, 1'b1}, CHROMA_CB_FIRST, 1,
              rgb_pair_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
      add_row(pair_type'{8'd0, 8'd128, 8'd255, 8'd128, 1'b0}, CHROMA_CB_FIRST, 1,
              rgb_pair_type'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0});
      add_row(pair_type'{8'h55, 8'd128, 8'hAA, 8'd128, 1'b1}, CHROMA_CB_FIRST, 1,
              rgb_pair_type'{8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 1'b1});
      add_row(pair_type'{8'd1, 8'd128, 8'd254, 8'd128, 1'b0}, CHROMA_CB_FIRST, 1,
              rgb_pair_type'{8'd1, 8'd1, 8'd1, 8'd254, 8'd254, 8'd254, 1'b0});
      // Saturation low and high
      add_row(pair_type'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd0, 8'd0, 8'd255, 8'd255, 1'b1}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd255, 8'd255, 8'd0, 8'd0, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd128, 8'd0, 8'd128, 8'd255, 1'b1}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd128, 8'd255, 8'd128, 8'd0, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      // Either side of the chroma zero point
      add_row(pair_type'{8'd128, 8'd127, 8'd127, 8'd129, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd1, 8'd1, 8'd254, 8'd254, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd0, 8'd128, 8'd255, 8'd0, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'd255, 8'd0, 8'd0, 8'd128, 1'b1}, CHROMA_CB_FIRST, 0, '0);
      add_row(pair_type'{8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0}, CHROMA_CB_FIRST, 0, '0);
      // Cr first
      add_row(pair_type'{8'd255, 8'd128, 8'd255, 8'd128, 1'b1}, CHROMA_CR_FIRST, 1,
              rgb_pair_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
      add_row(pair_type'{8'd0, 8'd0, 8'd255, 8'd255, 1'b0}, CHROMA_CR_FIRST, 0, '0);
      add_row(pair_type'{8'd128, 8'd0, 8'd128, 8'd255, 1'b1}, CHROMA_CR_FIRST, 0, '0);
      add_row(pair_type'{8'd0, 8'd128, 8'd255, 8'd0, 1'b0}, CHROMA_CR_FIRST, 0, '0);
      add_row(pair_type'{8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0}, CHROMA_CR_FIRST, 0, '0);

      // Reset value first, then walk the table
      csr_check();
      foreach (stim_table[i]) begin
         if (stim_table[i].order != chroma_order_model) begin
            settle();
            wd    = $urandom();
            wd[0] = stim_table[i].order;
            csr_write(ADDR_CHROMA_ORDER, wd);
            csr_check();
         end
         send_pair(stim_table[i].pair, stim_table[i].fixed, stim_table[i].want);
      end

      // Random phases: a write to an unmapped address, a new order, then traffic
      for (int ph = 0; ph < N_PHASES; ph++) begin
         settle();
         csr_write(ADDR_UNMAPPED, $urandom());
         csr_check();
         wd    = $urandom();
         wd[0] = PHASE_ORDER[ph];
         csr_write(ADDR_CHROMA_ORDER, wd);
         csr_check();
         snd_pct = PHASE_SND[ph];
         rcv_pct <= PHASE_RCV[ph];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (PHASE_HOLD[ph] && i == 100) begin
               hold_starts <= hold_starts + 1;
            end
            if (PHASE_DRAIN[ph] && i == 160) begin
               settle();
            end
            send_pair(random_pair(), 1'b0, '0);
         end
      end

      settle();
      if (mismatches == 0 && pending_rgb.size() == 0) begin
         $display("[ycbcr422_to_rgb_converter] OK");
      end else begin
         $display("[ycbcr422_to_rgb_converter] ERROR");
      end
      $finish;
   end

endmodule
